>>> sv/sdam_pkg.sv
// Shared types, constants and character tables of the Sobel direction ASCII mapper.
package sdam_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH     = 2'd0;
    localparam logic [1:0] REG_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [10:0] WIDTH_RST     = 11'd300;
    localparam logic [11:0] HEIGHT_RST    = 12'd240;
    localparam logic [7:0]  THRESHOLD_RST = 8'd50;

    // Q16 luma weights
    localparam logic [14:0] LUMA_WR = 15'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [12:0] LUMA_WB = 13'd7471;

    // Q16 tangents of 22.5 and 67.5 degrees
    localparam logic [14:0] TAN_LOW  = 15'd27146;
    localparam logic [17:0] TAN_HIGH = 18'd158218;

    // Largest square whose root does not exceed the clamp of 255
    localparam logic [20:0] SQ_CLAMP = 21'd65025;

    // Direction characters
    localparam logic [6:0] CH_BAR    = 7'd124;
    localparam logic [6:0] CH_UNDER  = 7'd95;
    localparam logic [6:0] CH_SLASH  = 7'd47;
    localparam logic [6:0] CH_BSLASH = 7'd92;

    // Request from front to back: 3x3 window, center luma, row end mark
    typedef struct packed {
        logic [8:0][7:0] win;
        logic [7:0]      luma;
        logic            row_end;
    } win_item_t;

    // Result request
    typedef struct packed {
        logic [6:0] char_code;
        logic       is_edge;
        logic [7:0] edge_level;
        logic       row_end;
    } result_t;

    // Brightness ramp " .:-=+*%#@"
    function automatic logic [6:0] ramp_char(input logic [3:0] idx);
        logic [6:0] ch;
        case (idx)
            4'd0:    ch = 7'd32;
            4'd1:    ch = 7'd46;
            4'd2:    ch = 7'd58;
            4'd3:    ch = 7'd45;
            4'd4:    ch = 7'd61;
            4'd5:    ch = 7'd43;
            4'd6:    ch = 7'd42;
            4'd7:    ch = 7'd37;
            4'd8:    ch = 7'd35;
            4'd9:    ch = 7'd64;
            default: ch = 7'd32;
        endcase
        return ch;
    endfunction

endpackage

>>> sv/sdam_fifo.sv
// Two-entry request queue.
module sdam_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

>>> sv/sdam_front.sv
// Front end: pixel intake, line buffers, luma, 3x3 window and border classification.
module sdam_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          edge_gray,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic [10:0]         width_cfg,
    input  logic [11:0]         height_cfg,
    output logic                item_push,
    output sdam_pkg::win_item_t item,
    input  logic                item_full
);
    import sdam_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > 12) ? CW + 1 : 12;

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_READ  = 3'b010,
        F_WRITE = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [7:0] upper_mem  [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];
    logic [7:0] luma_mem   [MAX_WIDTH];

    logic [CW-1:0] col_reg;
    logic [11:0]   row_reg;
    logic [CW-1:0] addr_reg;
    logic          emit_reg;
    logic          last_reg;
    logic [7:0]    gray_reg, red_reg, green_reg, blue_reg;
    logic [7:0]    up_rd_reg, mid_rd_reg, luma_rd_reg;
    logic [22:0]   pr_reg;
    logic [23:0]   pg_reg;
    logic [20:0]   pb_reg;
    logic [8:0][7:0] win_reg, win_next;
    logic [7:0]    dly0_reg;

    logic          accept;
    logic [LW-1:0] w_eff;
    logic [LW-1:0] col_inc;
    logic          last_col;
    logic [12:0]   row_inc;
    logic [24:0]   luma_sum;
    logic [7:0]    luma;

    assign accept = push && !full;
    assign full   = (state_reg != F_IDLE) || item_full;

    // Effective width and end-of-row test
    assign w_eff    = (LW'(width_cfg) > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : LW'(width_cfg);
    assign col_inc  = LW'(col_reg) + LW'(1);
    assign last_col = (col_inc >= w_eff);
    assign row_inc  = {1'b0, row_reg} + 13'd1;

    // Luma from registered products
    assign luma_sum = 25'(pr_reg) + 25'(pg_reg) + 25'(pb_reg);
    assign luma     = luma_sum[23:16];

    // Window shifted left with the new column on the right
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[2] = up_rd_reg;
        win_next[5] = mid_rd_reg;
        win_next[8] = gray_reg;
    end

    assign item_push    = (state_reg == F_WRITE) && emit_reg;
    assign item.win     = win_next;
    assign item.luma    = dly0_reg;
    assign item.row_end = last_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_READ;
            F_READ:  state_next = F_WRITE;
            F_WRITE: state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Line buffer memories
    always_ff @(posedge clk)
    begin
        if (state_reg == F_READ)
        begin
            up_rd_reg   <= upper_mem[addr_reg];
            mid_rd_reg  <= middle_mem[addr_reg];
            luma_rd_reg <= luma_mem[addr_reg];
        end
        if (state_reg == F_WRITE)
        begin
            upper_mem[addr_reg]  <= mid_rd_reg;
            middle_mem[addr_reg] <= gray_reg;
            luma_mem[addr_reg]   <= luma;
        end
    end

    // Pixel payload and luma products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gray_reg  <= edge_gray;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            addr_reg  <= col_reg;
            last_reg  <= last_col;
        end
        if (state_reg == F_READ)
        begin
            pr_reg <= 23'(LUMA_WR) * 23'(red_reg);
            pg_reg <= 24'(LUMA_WG) * 24'(green_reg);
            pb_reg <= 21'(LUMA_WB) * 21'(blue_reg);
        end
    end

    // Control, counters, window and luma delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            emit_reg  <= 1'b0;
            win_reg   <= '0;
            dly0_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                emit_reg <= (col_reg >= CW'(2)) && (row_reg >= 12'd2);
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= {1'b0, height_cfg}) ? 12'd0 : row_inc[11:0];
                end
                else
                begin
                    col_reg <= col_inc[CW-1:0];
                end
            end
            if (state_reg == F_WRITE)
            begin
                win_reg  <= win_next;
                dly0_reg <= luma_rd_reg;
            end
        end
    end
endmodule

>>> sv/sdam_back.sv
// Back end: Sobel gradients, magnitude root, direction and ramp character.
module sdam_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_empty,
    output logic                item_pop,
    input  sdam_pkg::win_item_t item,
    input  logic [7:0]          threshold_cfg,
    output logic                res_push,
    output sdam_pkg::result_t   res,
    input  logic                res_full
);
    import sdam_pkg::*;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_GRAD = 7'b0000010,
        B_PROD = 7'b0000100,
        B_SUM  = 7'b0001000,
        B_ROOT = 7'b0010000,
        B_FIN  = 7'b0100000,
        B_OUT  = 7'b1000000
    } bstate_t;

    bstate_t state_reg, state_next;

    win_item_t          item_reg;
    logic signed [11:0] gv_reg, gh_reg;
    logic [9:0]         a_reg;
    logic [19:0]        sqv_reg, sqh_reg;
    logic [24:0]        lo_reg;
    logic [27:0]        hi_reg;
    logic               same_reg;
    logic               zero_reg;
    logic [20:0]        n_reg;
    logic               horiz_reg, vert_reg;
    logic [7:0]         root_reg;
    logic [2:0]         bit_reg;
    result_t            res_reg;

    logic [9:0]         top_s, bot_s, lft_s, rgt_s;
    logic [9:0]         a_abs, b_abs;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;
    logic [15:0]        root_sq;
    logic [7:0]         mag;
    logic [6:0]         dir_ch;
    logic [11:0]        luma9;

    // Weighted row and column sums of the window
    assign top_s = 10'(item_reg.win[0]) + {1'b0, item_reg.win[1], 1'b0} + 10'(item_reg.win[2]);
    assign bot_s = 10'(item_reg.win[6]) + {1'b0, item_reg.win[7], 1'b0} + 10'(item_reg.win[8]);
    assign lft_s = 10'(item_reg.win[0]) + {1'b0, item_reg.win[3], 1'b0} + 10'(item_reg.win[6]);
    assign rgt_s = 10'(item_reg.win[2]) + {1'b0, item_reg.win[5], 1'b0} + 10'(item_reg.win[8]);

    assign a_abs = gv_reg[11] ? 10'(-gv_reg) : gv_reg[9:0];
    assign b_abs = gh_reg[11] ? 10'(-gh_reg) : gh_reg[9:0];

    // One root bit per cycle
    assign trial    = root_reg | (8'd1 << bit_reg);
    assign trial_sq = 16'(trial) * 16'(trial);
    assign root_sq  = 16'(root_reg) * 16'(root_reg);

    // Ceiling of the root, clamped
    assign mag = (n_reg > SQ_CLAMP) ? 8'd255
               : root_reg + ((21'(root_sq) < n_reg) ? 8'd1 : 8'd0);

    // Octant character
    always_comb
    begin
        if (zero_reg || horiz_reg)
        begin
            dir_ch = CH_BAR;
        end
        else if (vert_reg)
        begin
            dir_ch = CH_UNDER;
        end
        else if (same_reg)
        begin
            dir_ch = CH_SLASH;
        end
        else
        begin
            dir_ch = CH_BSLASH;
        end
    end

    assign luma9    = 12'(item_reg.luma) * 12'd9;
    assign item_pop = (state_reg == B_IDLE) && !item_empty;
    assign res_push = (state_reg == B_OUT);
    assign res      = res_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!item_empty) state_next = B_GRAD;
            B_GRAD:  state_next = B_PROD;
            B_PROD:  state_next = B_SUM;
            B_SUM:   state_next = B_ROOT;
            B_ROOT:  if (bit_reg == 3'd0) state_next = B_FIN;
            B_FIN:   state_next = B_OUT;
            B_OUT:   if (!res_full) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                item_reg <= item;
            end
            B_GRAD:
            begin
                gv_reg <= $signed({2'b00, top_s}) - $signed({2'b00, bot_s});
                gh_reg <= $signed({2'b00, lft_s}) - $signed({2'b00, rgt_s});
            end
            B_PROD:
            begin
                a_reg    <= a_abs;
                sqv_reg  <= 20'(a_abs) * 20'(a_abs);
                sqh_reg  <= 20'(b_abs) * 20'(b_abs);
                lo_reg   <= 25'(TAN_LOW) * 25'(b_abs);
                hi_reg   <= 28'(TAN_HIGH) * 28'(b_abs);
                same_reg <= ((gv_reg > 12'sd0) == (gh_reg > 12'sd0));
                zero_reg <= (gv_reg == 12'sd0) && (gh_reg == 12'sd0);
            end
            B_SUM:
            begin
                n_reg     <= 21'(sqv_reg) + 21'(sqh_reg);
                horiz_reg <= ({1'b0, a_reg, 16'd0} < 27'(lo_reg));
                vert_reg  <= ({2'b00, a_reg, 16'd0} >= hi_reg);
                root_reg  <= 8'd0;
                bit_reg   <= 3'd7;
            end
            B_ROOT:
            begin
                if (21'(trial_sq) <= n_reg)
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg - 3'd1;
            end
            B_FIN:
            begin
                res_reg.row_end <= item_reg.row_end;
                if (mag < threshold_cfg)
                begin
                    res_reg.char_code  <= ramp_char(luma9[11:8]);
                    res_reg.is_edge    <= 1'b0;
                    res_reg.edge_level <= 8'd0;
                end
                else
                begin
                    res_reg.char_code  <= dir_ch;
                    res_reg.is_edge    <= 1'b1;
                    res_reg.edge_level <= mag;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> sv/sobel_direction_ascii_mapper_core.sv
// Top level of the Sobel direction ASCII mapper.
// Pixels enter in raster order through a push/full queue port; one character request per
// interior pixel leaves through an empty/pop queue port. The front end takes a new pixel
// only after its line-buffer read and write-back states (single-port RAMs of MAX_WIDTH
// entries). The back end builds each character through gradient, product, sum, root,
// finish and output states, the root found one bit per cycle, and takes a new window only
// once the last character is handed on; border pixels pass the front end only. Two-entry
// queues sit between the front and back ends and at the result side. The user must write
// the registers (width, height, threshold) only while the block is idle; the block itself
// does not enforce this. Line buffers need no clearing after reset.
module sobel_direction_ascii_mapper_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  edge_gray,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  char_code,
    output logic        is_edge,
    output logic [7:0]  edge_level,
    output logic        row_end,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_wr_data
);
    import sdam_pkg::*;

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [7:0]  threshold_reg;

    logic        f_push, f_full, b_empty, b_pop, r_push, r_full;
    win_item_t   f_item, b_item;
    result_t     r_in, r_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WIDTH:     width_reg     <= cfg_wr_data[10:0];
                REG_HEIGHT:    height_reg    <= cfg_wr_data;
                REG_THRESHOLD: threshold_reg <= cfg_wr_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    sdam_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .edge_gray  (edge_gray),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .item_push  (f_push),
        .item       (f_item),
        .item_full  (f_full)
    );

    sdam_fifo #(.WIDTH($bits(win_item_t))) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_item),
        .full  (f_full),
        .pop   (b_pop),
        .rdata (b_item),
        .empty (b_empty)
    );

    sdam_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_empty    (b_empty),
        .item_pop      (b_pop),
        .item          (b_item),
        .threshold_cfg (threshold_reg),
        .res_push      (r_push),
        .res           (r_in),
        .res_full      (r_full)
    );

    sdam_fifo #(.WIDTH($bits(result_t))) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata (r_in),
        .full  (r_full),
        .pop   (pop),
        .rdata (r_out),
        .empty (empty)
    );

    assign char_code  = r_out.char_code;
    assign is_edge    = r_out.is_edge;
    assign edge_level = r_out.edge_level;
    assign row_end    = r_out.row_end;
endmodule

>>> sv/sdam_checker.sv
// Port-level checks of the mapper, bound to the top level.
module sdam_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [6:0] char_code,
    input logic       is_edge,
    input logic [7:0] edge_level
);
    // A waiting request holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_code) && $stable(edge_level)))
        else $error("result changed before pop");

    // Ramp characters carry no level
    a_ramp_level: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_edge) |-> (edge_level == 8'd0))
        else $error("ramp character with nonzero level");

    // Edge characters come from the direction set
    a_dir_char: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_edge) |-> (char_code == 7'd124 || char_code == 7'd95 ||
                                 char_code == 7'd47 || char_code == 7'd92))
        else $error("edge flag with non-direction character");

    // Characters stay printable
    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (char_code >= 7'd32 && char_code <= 7'd124))
        else $error("character out of range");
endmodule

bind sobel_direction_ascii_mapper_core sdam_checker u_sdam_checker (.*);
